// File: src/stt_pkg.sv
// Shared types and constants of the search transposition table.
package stt_pkg;

  localparam int INDEX_BITS = 18;
  localparam int SLOT_COUNT = 1 << INDEX_BITS;

  localparam int REQ_W   = 2;
  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 6;
  localparam int SCORE_W = 32;
  localparam int BOUND_W = 2;
  localparam int MOVE_W  = 13;

  localparam logic [REQ_W-1:0] REQ_STORE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
  localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
  localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd2;

  localparam int CMDQ_DEPTH = 4;
  localparam int CQ_PTR_W   = $clog2(CMDQ_DEPTH);
  localparam int CQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

  localparam int RESQ_DEPTH = 4;
  localparam int RQ_PTR_W   = $clog2(RESQ_DEPTH);
  localparam int RQ_CNT_W   = $clog2(RESQ_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_STORE,
    OP_LOOKUP,
    OP_CLEAR
  } op_t;

  typedef enum logic {
    BK_SWEEP,
    BK_RUN
  } back_state_t;

  typedef struct packed {
    op_t                       op;
    logic [KEY_W-1:0]          key;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] score;
    logic [BOUND_W-1:0]        bound;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] alpha;
    logic signed [SCORE_W-1:0] beta;
  } cmd_t;

  typedef struct packed {
    logic                      valid;
    logic [KEY_W-1:0]          key;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] score;
    logic [BOUND_W-1:0]        bound;
    logic [MOVE_W-1:0]         move;
  } slot_t;

  typedef struct packed {
    logic                      hit;
    logic                      move_found;
    logic [MOVE_W-1:0]         found_move;
    logic                      cutoff;
    logic signed [SCORE_W-1:0] cutoff_score;
  } res_t;

endpackage

// File: src/stt_front.sv
// Request decode: accepts input beats and turns them into table commands.
module stt_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [stt_pkg::REQ_W-1:0]           in_req_type,
  input  logic [stt_pkg::KEY_W-1:0]           in_lookup_key,
  input  logic [stt_pkg::DEPTH_W-1:0]         in_search_depth,
  input  logic signed [stt_pkg::SCORE_W-1:0]  in_entry_score,
  input  logic [stt_pkg::BOUND_W-1:0]         in_bound_kind,
  input  logic [stt_pkg::MOVE_W-1:0]          in_move_code,
  input  logic signed [stt_pkg::SCORE_W-1:0]  in_lower_window,
  input  logic signed [stt_pkg::SCORE_W-1:0]  in_upper_window,
  input  logic                                q_full,
  input  logic                                sweeping,
  output logic                                q_push,
  output stt_pkg::cmd_t                       q_data
);

  logic           known;
  stt_pkg::op_t   op;
  logic           hold_r;
  logic           hold_nxt;

  // Hold off input right after reset so the sweep flag is settled.
  assign hold_nxt = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b1;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  always_comb begin
    known = 1'b1;
    op    = stt_pkg::OP_STORE;
    unique case (in_req_type)
      stt_pkg::REQ_STORE:  op = stt_pkg::OP_STORE;
      stt_pkg::REQ_LOOKUP: op = stt_pkg::OP_LOOKUP;
      stt_pkg::REQ_CLEAR:  op = stt_pkg::OP_CLEAR;
      default:             known = 1'b0;
    endcase
  end

  assign in_full = q_full | sweeping | hold_r;

  // Drop unused request codes after the handshake.
  assign q_push = in_push & ~in_full & known;

  always_comb begin
    q_data       = '0;
    q_data.op    = op;
    q_data.key   = in_lookup_key;
    q_data.depth = in_search_depth;
    q_data.score = in_entry_score;
    q_data.bound = in_bound_kind;
    q_data.move  = in_move_code;
    q_data.alpha = in_lower_window;
    q_data.beta  = in_upper_window;
  end

endmodule

// File: src/stt_cmd_queue.sv
// Short command queue between the request decode and the table engine.
module stt_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  stt_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output stt_pkg::cmd_t rdata,
  output logic          empty
);

  stt_pkg::cmd_t                   slots_r [stt_pkg::CMDQ_DEPTH];
  logic [stt_pkg::CQ_PTR_W-1:0]    wptr_r;
  logic [stt_pkg::CQ_PTR_W-1:0]    wptr_nxt;
  logic [stt_pkg::CQ_PTR_W-1:0]    rptr_r;
  logic [stt_pkg::CQ_PTR_W-1:0]    rptr_nxt;
  logic [stt_pkg::CQ_CNT_W-1:0]    cnt_r;
  logic [stt_pkg::CQ_CNT_W-1:0]    cnt_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign full    = (cnt_r == stt_pkg::CQ_CNT_W'(stt_pkg::CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = slots_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wptr_r] <= wdata;
    end
  end

endmodule

// File: src/stt_res_queue.sv
// Result queue that holds lookup answers until the receiver pops them.
module stt_res_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  stt_pkg::res_t                 wdata,
  output logic [stt_pkg::RQ_CNT_W-1:0]  count,
  input  logic                          pop,
  output stt_pkg::res_t                 rdata,
  output logic                          empty
);

  stt_pkg::res_t                   slots_r [stt_pkg::RESQ_DEPTH];
  logic [stt_pkg::RQ_PTR_W-1:0]    wptr_r;
  logic [stt_pkg::RQ_PTR_W-1:0]    wptr_nxt;
  logic [stt_pkg::RQ_PTR_W-1:0]    rptr_r;
  logic [stt_pkg::RQ_PTR_W-1:0]    rptr_nxt;
  logic [stt_pkg::RQ_CNT_W-1:0]    cnt_r;
  logic [stt_pkg::RQ_CNT_W-1:0]    cnt_nxt;
  logic                            full;
  logic                            do_push;
  logic                            do_pop;

  assign full    = (cnt_r == stt_pkg::RQ_CNT_W'(stt_pkg::RESQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = slots_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wptr_r] <= wdata;
    end
  end

endmodule

// File: src/stt_back.sv
// Table engine: slot memory, read-modify-write pipeline and clearing sweep.
module stt_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  stt_pkg::cmd_t                 q_head,
  output logic                          q_pop,
  input  logic [stt_pkg::RQ_CNT_W-1:0]  res_count,
  output logic                          res_push,
  output stt_pkg::res_t                 res_data,
  output logic                          sweeping
);

  stt_pkg::slot_t                   mem [stt_pkg::SLOT_COUNT];

  stt_pkg::back_state_t             state_r;
  stt_pkg::back_state_t             state_nxt;
  logic [stt_pkg::INDEX_BITS-1:0]   sweep_idx_r;
  logic [stt_pkg::INDEX_BITS-1:0]   sweep_idx_nxt;
  logic                             b_valid_r;
  logic                             b_valid_nxt;
  stt_pkg::cmd_t                    b_cmd_r;
  stt_pkg::slot_t                   rd_data_r;
  logic                             fwd_valid_r;
  logic [stt_pkg::INDEX_BITS-1:0]   fwd_idx_r;
  stt_pkg::slot_t                   fwd_word_r;

  logic                             issue;
  logic                             res_room;
  logic [stt_pkg::INDEX_BITS-1:0]   rd_addr;
  logic [stt_pkg::INDEX_BITS-1:0]   b_idx;
  stt_pkg::slot_t                   word;
  logic                             hit;
  logic                             replace;
  logic                             deep_enough;
  logic                             bound_ok;
  logic                             cut;
  logic                             we;
  logic [stt_pkg::INDEX_BITS-1:0]   waddr;
  stt_pkg::slot_t                   wdata;

  assign sweeping = (state_r == stt_pkg::BK_SWEEP);
  assign rd_addr  = q_head.key[stt_pkg::INDEX_BITS-1:0];
  assign res_room = (res_count <= stt_pkg::RQ_CNT_W'(stt_pkg::RESQ_DEPTH - 2));

  always_comb begin
    state_nxt     = state_r;
    sweep_idx_nxt = sweep_idx_r;
    q_pop         = 1'b0;
    issue         = 1'b0;
    unique case (state_r)
      stt_pkg::BK_SWEEP: begin
        sweep_idx_nxt = sweep_idx_r + 1'b1;
        if (sweep_idx_r == '1) begin
          state_nxt = stt_pkg::BK_RUN;
        end
      end
      stt_pkg::BK_RUN: begin
        if (!q_empty) begin
          if (q_head.op == stt_pkg::OP_CLEAR) begin
            q_pop         = 1'b1;
            sweep_idx_nxt = '0;
            state_nxt     = stt_pkg::BK_SWEEP;
          end else if (q_head.op != stt_pkg::OP_LOOKUP || res_room) begin
            q_pop = 1'b1;
            issue = 1'b1;
          end
        end
      end
      default: state_nxt = stt_pkg::BK_SWEEP;
    endcase
  end

  assign b_valid_nxt = issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stt_pkg::BK_SWEEP;
      sweep_idx_r <= '0;
      b_valid_r   <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_idx_r <= sweep_idx_nxt;
      b_valid_r   <= b_valid_nxt;
      fwd_valid_r <= we;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_cmd_r <= q_head;
    end
    fwd_idx_r  <= waddr;
    fwd_word_r <= wdata;
  end

  // Take the write of the previous cycle, which the registered read missed.
  assign b_idx = b_cmd_r.key[stt_pkg::INDEX_BITS-1:0];
  assign word  = (fwd_valid_r && fwd_idx_r == b_idx) ? fwd_word_r : rd_data_r;

  assign hit         = word.valid & (word.key == b_cmd_r.key);
  assign replace     = ~hit | (b_cmd_r.depth >= word.depth);
  assign deep_enough = (word.depth >= b_cmd_r.depth);

  always_comb begin
    bound_ok = 1'b0;
    unique case (word.bound)
      stt_pkg::BOUND_EXACT: bound_ok = 1'b1;
      stt_pkg::BOUND_LOWER: bound_ok = ($signed(word.score) >= $signed(b_cmd_r.beta));
      stt_pkg::BOUND_UPPER: bound_ok = ($signed(word.score) <= $signed(b_cmd_r.alpha));
      default:              bound_ok = 1'b0;
    endcase
  end

  assign cut = hit & deep_enough & bound_ok;

  always_comb begin
    res_push              = b_valid_r & (b_cmd_r.op == stt_pkg::OP_LOOKUP);
    res_data              = '0;
    res_data.hit          = hit;
    res_data.move_found   = hit;
    res_data.found_move   = hit ? word.move : '0;
    res_data.cutoff       = cut;
    res_data.cutoff_score = cut ? word.score : '0;
  end

  always_comb begin
    we    = 1'b0;
    waddr = b_idx;
    wdata = '0;
    if (state_r == stt_pkg::BK_SWEEP) begin
      we    = 1'b1;
      waddr = sweep_idx_r;
    end else if (b_valid_r && b_cmd_r.op == stt_pkg::OP_STORE && replace) begin
      we          = 1'b1;
      wdata.valid = 1'b1;
      wdata.key   = b_cmd_r.key;
      wdata.depth = b_cmd_r.depth;
      wdata.score = b_cmd_r.score;
      wdata.bound = b_cmd_r.bound;
      wdata.move  = b_cmd_r.move;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  a_no_exec_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == stt_pkg::BK_SWEEP && b_valid_r))
    else $error("command in execute stage during sweep");

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (res_count < stt_pkg::RQ_CNT_W'(stt_pkg::RESQ_DEPTH)))
    else $error("lookup result pushed into a full result queue");

  a_sweep_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == stt_pkg::BK_SWEEP) |-> (sweep_idx_r == '0))
    else $error("sweep did not start at slot zero");

  a_no_issue_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stt_pkg::BK_SWEEP) |=> !b_valid_r)
    else $error("command issued while sweeping");

endmodule

// File: src/search_transposition_table.sv
// Top level of the search transposition table.
//
// Input channel: drive push with a request; it is taken on a rising edge
// with full low. Request kinds are store, lookup and clear; an unused
// request code is taken and dropped. Only lookups give a result beat.
// Result channel: while empty is low the oldest lookup answer is on the
// out_ ports; pop on a rising edge takes it.
// A lookup passes through the command queue, the engine's execute stage and
// the result queue. Store and lookup run at one beat per cycle while no sweep
// runs and the result queue has room, set by the single read-modify-write pass
// over the slot memory; a store followed at once by a request to the same slot
// sees the stored data. Clear walks all 262144 slots, one per cycle, during
// which full is high. After reset the same sweep runs before the first request is
// taken. When the receiver stalls, answers wait in a four-deep result queue
// and the engine stops issuing lookups; requests then collect in a four-deep
// command queue until full rises.
module search_transposition_table (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic [stt_pkg::REQ_W-1:0]           in_req_type,
  input  logic [stt_pkg::KEY_W-1:0]           in_lookup_key,
  input  logic [stt_pkg::DEPTH_W-1:0]         in_search_depth,
  input  logic signed [stt_pkg::SCORE_W-1:0]  in_entry_score,
  input  logic [stt_pkg::BOUND_W-1:0]         in_bound_kind,
  input  logic [stt_pkg::MOVE_W-1:0]          in_move_code,
  input  logic signed [stt_pkg::SCORE_W-1:0]  in_lower_window,
  input  logic signed [stt_pkg::SCORE_W-1:0]  in_upper_window,
  output logic                                empty,
  input  logic                                pop,
  output logic                                out_entry_hit,
  output logic                                out_move_found,
  output logic [stt_pkg::MOVE_W-1:0]          out_found_move,
  output logic                                out_cutoff,
  output logic signed [stt_pkg::SCORE_W-1:0]  out_cutoff_score
);

  logic                           cq_push;
  stt_pkg::cmd_t                  cq_wdata;
  logic                           cq_full;
  logic                           cq_pop;
  stt_pkg::cmd_t                  cq_head;
  logic                           cq_empty;
  logic                           sweeping;
  logic                           rq_push;
  stt_pkg::res_t                  rq_wdata;
  logic [stt_pkg::RQ_CNT_W-1:0]   rq_count;
  stt_pkg::res_t                  rq_head;

  stt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (push),
    .in_full         (full),
    .in_req_type     (in_req_type),
    .in_lookup_key   (in_lookup_key),
    .in_search_depth (in_search_depth),
    .in_entry_score  (in_entry_score),
    .in_bound_kind   (in_bound_kind),
    .in_move_code    (in_move_code),
    .in_lower_window (in_lower_window),
    .in_upper_window (in_upper_window),
    .q_full          (cq_full),
    .sweeping        (sweeping),
    .q_push          (cq_push),
    .q_data          (cq_wdata)
  );

  stt_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .wdata (cq_wdata),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_head),
    .empty (cq_empty)
  );

  stt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (cq_empty),
    .q_head    (cq_head),
    .q_pop     (cq_pop),
    .res_count (rq_count),
    .res_push  (rq_push),
    .res_data  (rq_wdata),
    .sweeping  (sweeping)
  );

  stt_res_queue u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata (rq_wdata),
    .count (rq_count),
    .pop   (pop),
    .rdata (rq_head),
    .empty (empty)
  );

  assign out_entry_hit    = rq_head.hit;
  assign out_move_found   = rq_head.move_found;
  assign out_found_move   = rq_head.found_move;
  assign out_cutoff       = rq_head.cutoff;
  assign out_cutoff_score = rq_head.cutoff_score;

endmodule

// File: sim/tb_search_transposition_table.sv
// Self-checking testbench for the search transposition table: store, lookup and clear traffic.
module tb_search_transposition_table;

  localparam logic [stt_pkg::REQ_W-1:0]   REQ_UNUSED   = 2'd3;
  localparam logic [stt_pkg::BOUND_W-1:0] BOUND_UNUSED = 2'd3;
  localparam int STALL_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 80;
  localparam int PHASE_ITEMS   = 165;
  localparam int KEY_POOL_SIZE = 18;

  typedef struct packed {
    logic [stt_pkg::REQ_W-1:0]          req;
    logic [stt_pkg::KEY_W-1:0]          key;
    logic [stt_pkg::DEPTH_W-1:0]        depth;
    logic signed [stt_pkg::SCORE_W-1:0] score;
    logic [stt_pkg::BOUND_W-1:0]        bound;
    logic [stt_pkg::MOVE_W-1:0]         move;
    logic signed [stt_pkg::SCORE_W-1:0] alpha;
    logic signed [stt_pkg::SCORE_W-1:0] beta;
  } tt_request_t;

  class table_mirror_t;
    bit                                 slot_valid    [int];
    bit                                 slot_has_move [int];
    logic [stt_pkg::KEY_W-1:0]          slot_key      [int];
    logic [stt_pkg::DEPTH_W-1:0]        slot_depth    [int];
    logic signed [stt_pkg::SCORE_W-1:0] slot_score    [int];
    logic [stt_pkg::BOUND_W-1:0]        slot_bound    [int];
    logic [stt_pkg::MOVE_W-1:0]         slot_move     [int];
    stt_pkg::res_t                      pending_answers[$];
    int unsigned                        error_count;

    function void note_request(tt_request_t r);
      int            idx;
      stt_pkg::res_t ans;
      idx = int'(r.key[stt_pkg::INDEX_BITS-1:0]);
      ans = '0;
      unique case (r.req)
        stt_pkg::REQ_CLEAR: begin
          slot_valid.delete();
        end
        stt_pkg::REQ_STORE: begin
          if (!slot_valid.exists(idx) || slot_key[idx] != r.key ||
              r.depth >= slot_depth[idx]) begin
            slot_valid[idx]    = 1'b1;
            slot_has_move[idx] = 1'b1;
            slot_key[idx]      = r.key;
            slot_depth[idx]    = r.depth;
            slot_score[idx]    = r.score;
            slot_bound[idx]    = r.bound;
            slot_move[idx]     = r.move;
          end else if (!slot_has_move.exists(idx)) begin
            slot_has_move[idx] = 1'b1;
            slot_move[idx]     = r.move;
          end
        end
        stt_pkg::REQ_LOOKUP: begin
          if (slot_valid.exists(idx) && slot_key[idx] == r.key) begin
            ans.hit = 1'b1;
            if (slot_has_move.exists(idx)) begin
              ans.move_found = 1'b1;
              ans.found_move = slot_move[idx];
            end
            if (slot_depth[idx] >= r.depth &&
                (slot_bound[idx] == stt_pkg::BOUND_EXACT ||
                 (slot_bound[idx] == stt_pkg::BOUND_LOWER && slot_score[idx] >= r.beta) ||
                 (slot_bound[idx] == stt_pkg::BOUND_UPPER && slot_score[idx] <= r.alpha)))
            begin
              ans.cutoff       = 1'b1;
              ans.cutoff_score = slot_score[idx];
            end
          end
          pending_answers.insert(pending_answers.size(), ans);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_answer(stt_pkg::res_t got);
      stt_pkg::res_t exp;
      if (pending_answers.size() == 0) begin
        $display("%0t: result beat with none expected, actual %0d %0d %0d %0d %0d",
                 $time, got.hit, got.move_found, got.found_move, got.cutoff,
                 got.cutoff_score);
        error_count++;
        return;
      end
      exp = pending_answers.pop_front();
      if (got.hit !== exp.hit) begin
        $display("%0t: entry_hit expected %0d actual %0d", $time, exp.hit, got.hit);
        error_count++;
      end
      if (got.move_found !== exp.move_found) begin
        $display("%0t: move_found expected %0d actual %0d", $time, exp.move_found,
                 got.move_found);
        error_count++;
      end
      if (got.found_move !== exp.found_move) begin
        $display("%0t: found_move expected %0d actual %0d", $time, exp.found_move,
                 got.found_move);
        error_count++;
      end
      if (got.cutoff !== exp.cutoff) begin
        $display("%0t: cutoff expected %0d actual %0d", $time, exp.cutoff, got.cutoff);
        error_count++;
      end
      if (got.cutoff_score !== exp.cutoff_score) begin
        $display("%0t: cutoff_score expected %0d actual %0d", $time, exp.cutoff_score,
                 got.cutoff_score);
        error_count++;
      end
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction
  endclass

  logic                               clk;
  logic                               rst_n;
  logic                               push;
  logic                               full;
  logic [stt_pkg::REQ_W-1:0]          in_req_type;
  logic [stt_pkg::KEY_W-1:0]          in_lookup_key;
  logic [stt_pkg::DEPTH_W-1:0]        in_search_depth;
  logic signed [stt_pkg::SCORE_W-1:0] in_entry_score;
  logic [stt_pkg::BOUND_W-1:0]        in_bound_kind;
  logic [stt_pkg::MOVE_W-1:0]         in_move_code;
  logic signed [stt_pkg::SCORE_W-1:0] in_lower_window;
  logic signed [stt_pkg::SCORE_W-1:0] in_upper_window;
  logic                               empty;
  logic                               pop;
  logic                               out_entry_hit;
  logic                               out_move_found;
  logic [stt_pkg::MOVE_W-1:0]         out_found_move;
  logic                               out_cutoff;
  logic signed [stt_pkg::SCORE_W-1:0] out_cutoff_score;

  table_mirror_t             mirror;
  int                        send_idle_pct;
  int                        recv_idle_pct;
  bit                        hold_results;
  int unsigned               quiet_cycles;
  logic [stt_pkg::KEY_W-1:0] key_pool [KEY_POOL_SIZE];

  search_transposition_table i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_req_type      (in_req_type),
    .in_lookup_key    (in_lookup_key),
    .in_search_depth  (in_search_depth),
    .in_entry_score   (in_entry_score),
    .in_bound_kind    (in_bound_kind),
    .in_move_code     (in_move_code),
    .in_lower_window  (in_lower_window),
    .in_upper_window  (in_upper_window),
    .empty            (empty),
    .pop              (pop),
    .out_entry_hit    (out_entry_hit),
    .out_move_found   (out_move_found),
    .out_found_move   (out_found_move),
    .out_cutoff       (out_cutoff),
    .out_cutoff_score (out_cutoff_score)
  );

  always #10 clk = ~clk;

  function automatic tt_request_t make_request(
    logic [stt_pkg::REQ_W-1:0] req, logic [stt_pkg::KEY_W-1:0] key,
    logic [stt_pkg::DEPTH_W-1:0] depth, logic signed [stt_pkg::SCORE_W-1:0] score,
    logic [stt_pkg::BOUND_W-1:0] bound, logic [stt_pkg::MOVE_W-1:0] move,
    logic signed [stt_pkg::SCORE_W-1:0] alpha, logic signed [stt_pkg::SCORE_W-1:0] beta);
    tt_request_t r;
    r.req   = req;
    r.key   = key;
    r.depth = depth;
    r.score = score;
    r.bound = bound;
    r.move  = move;
    r.alpha = alpha;
    r.beta  = beta;
    return r;
  endfunction

  function automatic logic signed [stt_pkg::SCORE_W-1:0] pick_score();
    unique case ($urandom_range(3))
      0: return $urandom;
      1: begin
        unique case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return int'($urandom_range(16)) - 8;
    endcase
  endfunction

  function automatic tt_request_t random_request();
    tt_request_t r;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 47) r.req = stt_pkg::REQ_STORE;
    else if (pick < 95) r.req = stt_pkg::REQ_LOOKUP;
    else r.req = REQ_UNUSED;
    if ($urandom_range(99) < 85) r.key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
    else r.key = {$urandom, $urandom};
    r.depth = ($urandom_range(1) != 0) ? stt_pkg::DEPTH_W'($urandom_range(63)) :
                                         stt_pkg::DEPTH_W'($urandom_range(7));
    r.score = pick_score();
    r.bound = ($urandom_range(15) == 0) ? BOUND_UNUSED :
                                          stt_pkg::BOUND_W'($urandom_range(2));
    r.move  = stt_pkg::MOVE_W'($urandom);
    r.alpha = pick_score();
    r.beta  = pick_score();
    return r;
  endfunction

  task automatic push_request(input tt_request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push            <= 1'b1;
    in_req_type     <= r.req;
    in_lookup_key   <= r.key;
    in_search_depth <= r.depth;
    in_entry_score  <= r.score;
    in_bound_kind   <= r.bound;
    in_move_code    <= r.move;
    in_lower_window <= r.alpha;
    in_upper_window <= r.beta;
    do @(posedge clk); while (full);
    mirror.note_request(r);
  endtask

  task automatic wait_all_answers();
    push <= 1'b0;
    do @(posedge clk); while (mirror.pending() != 0);
  endtask

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    stt_pkg::res_t got;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        got.hit          = out_entry_hit;
        got.move_found   = out_move_found;
        got.found_move   = out_found_move;
        got.cutoff       = out_cutoff;
        got.cutoff_score = out_cutoff_score;
        mirror.check_answer(got);
      end
      if (hold_results) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    logic [stt_pkg::KEY_W-1:0]          k_ones;
    logic [stt_pkg::KEY_W-1:0]          k_zero;
    logic [stt_pkg::KEY_W-1:0]          k_alias;
    logic signed [stt_pkg::SCORE_W-1:0] s_min;
    logic signed [stt_pkg::SCORE_W-1:0] s_max;
    logic [stt_pkg::INDEX_BITS-1:0]     base_index;
    mirror          = new();
    clk             = 1'b0;
    rst_n           = 1'b0;
    push            = 1'b0;
    in_req_type     = stt_pkg::REQ_STORE;
    in_lookup_key   = '0;
    in_search_depth = '0;
    in_entry_score  = '0;
    in_bound_kind   = stt_pkg::BOUND_EXACT;
    in_move_code    = '0;
    in_lower_window = '0;
    in_upper_window = '0;
    pop             = 1'b0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    hold_results    = 1'b0;
    k_ones          = '1;
    k_zero          = '0;
    k_alias         = 64'h5A5A_0000_0004_0000;
    s_min           = 32'sh8000_0000;
    s_max           = 32'sh7FFF_FFFF;
    for (int i = 0; i < KEY_POOL_SIZE; i++) begin
      if (i % 3 == 0) base_index = stt_pkg::INDEX_BITS'($urandom);
      key_pool[i] = {$urandom, $urandom};
      key_pool[i][stt_pkg::INDEX_BITS-1:0] = base_index;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    push_request(make_request(stt_pkg::REQ_LOOKUP, k_zero, 0, 0,
                              stt_pkg::BOUND_EXACT, 0, s_min, s_max));
    push_request(make_request(stt_pkg::REQ_STORE, k_ones, 63, s_max,
                              stt_pkg::BOUND_EXACT, 13'h1FFF, 0, 0));
    push_request(make_request(stt_pkg::REQ_LOOKUP, k_ones, 63, 0,
                              stt_pkg::BOUND_EXACT, 0, s_min, s_max));
    push_request(make_request(stt_pkg::REQ_STORE, k_zero, 0, s_min,
                              stt_pkg::BOUND_LOWER, 0, 0, 0));
    push_request(make_request(stt_pkg::REQ_LOOKUP, k_zero, 0, 0,
                              stt_pkg::BOUND_EXACT, 0, s_max, s_min));
    push_request(make_request(stt_pkg::REQ_LOOKUP, k_zero, 0, 0,
                              stt_pkg::BOUND_EXACT, 0, s_max, s_min + 1));
    push_request(make_request(stt_pkg::REQ_LOOKUP, k_zero, 1, 0,
                              stt_pkg::BOUND_EXACT, 0, s_max, s_min));
    push_request(make_request(stt_pkg::REQ_STORE, k_zero, 0, 100,
                              stt_pkg::BOUND_UPPER, 5, 0, 0));
    push_request(make_request(stt_pkg::REQ_LOOKUP, k_zero, 0, 0,
                              stt_pkg::BOUND_EXACT, 0, 100, s_max));
    push_request(make_request(stt_pkg::REQ_LOOKUP, k_zero, 0, 0,
                              stt_pkg::BOUND_EXACT, 0, 99, s_min));
    push_request(make_request(stt_pkg::REQ_STORE, k_alias, 10, 7,
                              stt_pkg::BOUND_EXACT, 13'h1555, 0, 0));
    push_request(make_request(stt_pkg::REQ_LOOKUP, k_zero, 0, 0,
                              stt_pkg::BOUND_EXACT, 0, s_max, s_min));
    push_request(make_request(stt_pkg::REQ_STORE, k_alias, 5, 9,
                              stt_pkg::BOUND_UPPER, 13'h0AAA, 0, 0));
    push_request(make_request(stt_pkg::REQ_LOOKUP, k_alias, 10, 0,
                              stt_pkg::BOUND_EXACT, 0, s_min, s_max));
    push_request(make_request(stt_pkg::REQ_LOOKUP, k_alias, 11, 0,
                              stt_pkg::BOUND_EXACT, 0, s_max, s_min));
    push_request(make_request(stt_pkg::REQ_STORE, k_ones, 63, 3,
                              BOUND_UNUSED, 1, 0, 0));
    push_request(make_request(stt_pkg::REQ_LOOKUP, k_ones, 0, 0,
                              stt_pkg::BOUND_EXACT, 0, s_max, s_min));
    push_request(make_request(REQ_UNUSED, k_ones, 0, 0,
                              stt_pkg::BOUND_EXACT, 2, 0, 0));
    push_request(make_request(stt_pkg::REQ_LOOKUP, k_ones, 0, 0,
                              stt_pkg::BOUND_EXACT, 0, s_max, s_min));
    push_request(make_request(stt_pkg::REQ_CLEAR, k_ones, 0, 0,
                              stt_pkg::BOUND_EXACT, 0, 0, 0));
    push_request(make_request(stt_pkg::REQ_LOOKUP, k_ones, 0, 0,
                              stt_pkg::BOUND_EXACT, 0, s_max, s_min));
    push_request(make_request(stt_pkg::REQ_STORE, k_ones, 0, -1,
                              stt_pkg::BOUND_LOWER, 13'h1000, 0, 0));
    push_request(make_request(stt_pkg::REQ_LOOKUP, k_ones, 0, 0,
                              stt_pkg::BOUND_EXACT, 0, s_min, -1));

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 65 : 0;
      recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 36 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == 30) hold_results = 1'b1;
        push_request(random_request());
      end
      if (phase == 0) wait_all_answers();
    end

    push <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mirror.error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
